>>> sv/ocws_pkg.sv
// Shared types and constants for the omni chassis wheel speed pipeline.
// No dependencies.
package ocws_pkg;

   localparam int WHEEL_COUNT = 4;
   localparam int AXIS_COUNT  = 3;
   localparam int SPEED_WIDTH = 16;

   localparam int VEL_W   = 16;
   localparam int COEF_W  = 16;
   localparam int SCALE_W = 16;
   localparam int LIMIT_W = 15;
   localparam int PROD_W  = VEL_W + COEF_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int RPM_W   = ACC_W + SCALE_W + 1;
   localparam int MAG_W   = 48;
   localparam int FRAC    = 28;
   localparam int WHOLE_W = MAG_W - FRAC;
   localparam int NUM_W   = MAG_W + LIMIT_W;
   localparam int DIV_STEPS = LIMIT_W;
   localparam int CMP_W   = ((SPEED_WIDTH > WHOLE_W) ? SPEED_WIDTH : WHOLE_W) + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = AXIS_COUNT * COEF_W;

   localparam logic [CSR_IDX_W-1:0] REG_COEFF_FL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_FR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_RL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_RR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RPM_SCALE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RPM_LIMIT = 3'd5;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd8231;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd9000;

   typedef logic [WHEEL_COUNT-1:0][CSR_DATA_W-1:0] coeff_set_type;
   typedef logic signed [AXIS_COUNT-1:0][VEL_W-1:0] vel_type;

   typedef struct packed {
      logic                                 valid;
      logic                                 clip;
      logic [MAG_W-1:0]                     max;
      logic [WHEEL_COUNT-1:0]               neg;
      logic [WHEEL_COUNT-1:0][WHOLE_W-1:0]  whole;
      logic [WHEEL_COUNT-1:0][NUM_W-1:0]    num;
   } front_type;

   typedef struct packed {
      logic                                 clip;
      logic [WHEEL_COUNT-1:0]               neg;
      logic [WHEEL_COUNT-1:0][WHOLE_W-1:0]  whole;
   } side_type;

endpackage

>>> sv/omni_chassis_wheel_speeds.sv
// Top level: omni chassis inverse kinematics, config registers, divider bank, output.
// Depends on ocws_pkg, ocws_front, ocws_div.
//
//   channel   ports                       handshake
//   request   req_*                       start & !busy
//   result    rsp_*                       rsp_valid, one cycle
//   config    csr_we, csr_index, csr_data csr_we
//
// A request may be taken every cycle; busy is always low.
// Each request passes through 6 front stages (multiply, sum,
// scale, magnitude, maximum, limit product), 15 divider stages and 1 output stage.
// Synchronous reset clears the valid line and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
module omni_chassis_wheel_speeds
   import ocws_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VEL_W-1:0]       req_lin_x,
   input  logic signed [VEL_W-1:0]       req_lin_y,
   input  logic signed [VEL_W-1:0]       req_turn_rate,
   output logic                          rsp_valid,
   output logic signed [SPEED_WIDTH-1:0] rsp_rpm_front_left,
   output logic signed [SPEED_WIDTH-1:0] rsp_rpm_front_right,
   output logic signed [SPEED_WIDTH-1:0] rsp_rpm_rear_left,
   output logic signed [SPEED_WIDTH-1:0] rsp_rpm_rear_right,
   output logic                          rsp_clipped,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   coeff_set_type       coeffs_ff;
   logic [SCALE_W-1:0]  scale_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   vel_type             vel;
   front_type           front;
   logic [DIV_STEPS-1:0] quot [WHEEL_COUNT];
   logic [DIV_STEPS-1:0] valid_line_ff;
   side_type             side_ff [DIV_STEPS];
   logic                 out_valid_ff;
   logic [WHEEL_COUNT-1:0][SPEED_WIDTH-1:0] rpm_ff, rpm_in;
   logic                 clip_ff;
   logic [CMP_W-1:0]     mag_c [WHEEL_COUNT];
   logic [CMP_W-1:0]     half;
   side_type             last;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeffs_ff <= '0;
         scale_ff  <= SCALE_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_COEFF_FL:  coeffs_ff[0] <= csr_data;
            REG_COEFF_FR:  coeffs_ff[1] <= csr_data;
            REG_COEFF_RL:  coeffs_ff[2] <= csr_data;
            REG_COEFF_RR:  coeffs_ff[3] <= csr_data;
            REG_RPM_SCALE: scale_ff <= csr_data[SCALE_W-1:0];
            REG_RPM_LIMIT: limit_ff <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy   = 1'b0;
   assign vel[0] = req_lin_x;
   assign vel[1] = req_lin_y;
   assign vel[2] = req_turn_rate;

   ocws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .vel       (vel),
      .coeffs    (coeffs_ff),
      .rpm_scale (scale_ff),
      .rpm_limit (limit_ff),
      .out       (front)
   );

   for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_div
      ocws_div u_div (
         .clock (clock),
         .num   (front.num[w]),
         .den   (front.max),
         .quot  (quot[w])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_line_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         valid_line_ff <= {valid_line_ff[DIV_STEPS-2:0], front.valid};
         out_valid_ff  <= valid_line_ff[DIV_STEPS-1];
      end
      side_ff[0].clip  <= front.clip;
      side_ff[0].neg   <= front.neg;
      side_ff[0].whole <= front.whole;
      for (int s = 1; s < DIV_STEPS; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
      rpm_ff  <= rpm_in;
      clip_ff <= side_ff[DIV_STEPS-1].clip;
   end

   always_comb begin
      last = side_ff[DIV_STEPS-1];
      half = CMP_W'(1) << (SPEED_WIDTH - 1);
      for (int w = 0; w < WHEEL_COUNT; w++) begin
         mag_c[w] = last.clip ? CMP_W'(quot[w]) : CMP_W'(last.whole[w]);
         if (last.neg[w]) begin
            if (mag_c[w] > half) mag_c[w] = half;
            rpm_in[w] = SPEED_WIDTH'(-mag_c[w]);
         end else begin
            if (mag_c[w] > half - CMP_W'(1)) mag_c[w] = half - CMP_W'(1);
            rpm_in[w] = SPEED_WIDTH'(mag_c[w]);
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_rpm_front_left  = rpm_ff[0];
   assign rsp_rpm_front_right = rpm_ff[1];
   assign rsp_rpm_rear_left   = rpm_ff[2];
   assign rsp_rpm_rear_right  = rpm_ff[3];
   assign rsp_clipped         = clip_ff;

endmodule

>>> sv/ocws_front.sv
// Front pipeline: matrix product, RPM scaling, magnitudes, maximum, limit check.
// Depends on ocws_pkg.
module ocws_front
   import ocws_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  vel_type             vel,
   input  coeff_set_type       coeffs,
   input  logic [SCALE_W-1:0]  rpm_scale,
   input  logic [LIMIT_W-1:0]  rpm_limit,
   output front_type           out
);

   logic signed [PROD_W-1:0] prod_ff [WHEEL_COUNT][AXIS_COUNT];
   logic signed [ACC_W-1:0]  acc_ff  [WHEEL_COUNT];
   logic signed [RPM_W-1:0]  rpm_ff  [WHEEL_COUNT];
   logic [MAG_W-1:0]         mag4_ff [WHEEL_COUNT];
   logic [WHEEL_COUNT-1:0]   neg4_ff;
   logic [MAG_W-1:0]         mag5_ff [WHEEL_COUNT];
   logic [WHEEL_COUNT-1:0]   neg5_ff;
   logic [MAG_W-1:0]         max5_ff;
   logic [4:0]               valid_ff;
   front_type                out_ff;
   logic [MAG_W-1:0]         max_a, max_b, max_in;

   always_comb begin
      max_a  = (mag4_ff[0] > mag4_ff[1]) ? mag4_ff[0] : mag4_ff[1];
      max_b  = (mag4_ff[2] > mag4_ff[3]) ? mag4_ff[2] : mag4_ff[3];
      max_in = (max_a > max_b) ? max_a : max_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_ff.valid <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[3:0], in_valid};
         out_ff.valid <= valid_ff[4];
      end
      for (int w = 0; w < WHEEL_COUNT; w++) begin
         for (int j = 0; j < AXIS_COUNT; j++) begin
            prod_ff[w][j] <= $signed(coeffs[w][j*COEF_W +: COEF_W]) * $signed(vel[j]);
         end
         acc_ff[w] <= ACC_W'(prod_ff[w][0]) + ACC_W'(prod_ff[w][1])
                      + ACC_W'(prod_ff[w][2]);
         rpm_ff[w] <= acc_ff[w] * $signed({1'b0, rpm_scale});
         neg4_ff[w] <= rpm_ff[w][RPM_W-1];
         mag4_ff[w] <= rpm_ff[w][RPM_W-1] ? MAG_W'(-rpm_ff[w]) : MAG_W'(rpm_ff[w]);
         mag5_ff[w] <= mag4_ff[w];
         neg5_ff[w] <= neg4_ff[w];
         out_ff.neg[w]   <= neg5_ff[w];
         out_ff.whole[w] <= mag5_ff[w][MAG_W-1:FRAC];
         out_ff.num[w]   <= NUM_W'(mag5_ff[w]) * NUM_W'(rpm_limit);
      end
      max5_ff    <= max_in;
      out_ff.max <= max5_ff;
      out_ff.clip <= max5_ff > {(MAG_W-LIMIT_W-FRAC)'(0), rpm_limit, FRAC'(0)};
   end

   assign out = out_ff;

endmodule

>>> sv/ocws_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ocws_pkg; quotient must fit in DIV_STEPS bits.
module ocws_div
   import ocws_pkg::*;
(
   input  logic                 clock,
   input  logic [NUM_W-1:0]     num,
   input  logic [MAG_W-1:0]     den,
   output logic [DIV_STEPS-1:0] quot
);

   logic [MAG_W-1:0]     rem_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] low_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS];
   logic [MAG_W-1:0]     den_ff [DIV_STEPS];

   logic [MAG_W-1:0]     rem_src [DIV_STEPS];
   logic [DIV_STEPS-1:0] low_src [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_src   [DIV_STEPS];
   logic [MAG_W-1:0]     den_src [DIV_STEPS];
   logic [MAG_W:0]       trial   [DIV_STEPS];
   logic [MAG_W:0]       diff    [DIV_STEPS];
   logic                 ge      [DIV_STEPS];

   always_comb begin
      rem_src[0] = num[NUM_W-1:DIV_STEPS];
      low_src[0] = num[DIV_STEPS-1:0];
      q_src[0]   = '0;
      den_src[0] = den;
      for (int s = 1; s < DIV_STEPS; s++) begin
         rem_src[s] = rem_ff[s-1];
         low_src[s] = low_ff[s-1];
         q_src[s]   = q_ff[s-1];
         den_src[s] = den_ff[s-1];
      end
      for (int s = 0; s < DIV_STEPS; s++) begin
         trial[s] = {rem_src[s], low_src[s][DIV_STEPS-1]};
         diff[s]  = trial[s] - {1'b0, den_src[s]};
         ge[s]    = trial[s] >= {1'b0, den_src[s]};
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
         rem_ff[s] <= ge[s] ? diff[s][MAG_W-1:0] : trial[s][MAG_W-1:0];
         low_ff[s] <= {low_src[s][DIV_STEPS-2:0], 1'b0};
         q_ff[s]   <= {q_src[s][DIV_STEPS-2:0], ge[s]};
         den_ff[s] <= den_src[s];
      end
   end

   assign quot = q_ff[DIV_STEPS-1];

endmodule

>>> dv/tb_omni_chassis_wheel_speeds.sv
// Testbench for omni_chassis_wheel_speeds: drives velocity requests, predicts the four wheel
// RPM commands and the clipped flag, and checks each response in order.
// Depends on ocws_pkg and the omni_chassis_wheel_speeds RTL.
module tb_omni_chassis_wheel_speeds;
   import ocws_pkg::*;

   typedef struct {
      logic signed [VEL_W-1:0] x, y, t;
   } vel_cmd_t;

   typedef struct {
      logic signed [SPEED_WIDTH-1:0] rpm [WHEEL_COUNT];
      logic                          clip;
   } wheel_cmd_t;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [VEL_W-1:0] req_lin_x = '0, req_lin_y = '0, req_turn_rate = '0;
   logic rsp_valid;
   logic signed [SPEED_WIDTH-1:0] rsp_rpm_front_left, rsp_rpm_front_right;
   logic signed [SPEED_WIDTH-1:0] rsp_rpm_rear_left, rsp_rpm_rear_right;
   logic rsp_clipped;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   omni_chassis_wheel_speeds dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [CSR_DATA_W-1:0] coeff_q [WHEEL_COUNT];
   logic [SCALE_W-1:0]    scale_q;
   logic [LIMIT_W-1:0]    limit_q;

   vel_cmd_t   pending_q [$];
   wheel_cmd_t wheel_expect_q [$];
   bit         quiet;
   int         errors;
   int         sent;
   string      wheel_names [WHEEL_COUNT] = '{"rpm_front_left", "rpm_front_right",
                                             "rpm_rear_left", "rpm_rear_right"};

   function automatic wheel_cmd_t wheel_speeds(vel_cmd_t v);
      wheel_cmd_t r;
      longint signed acc, rpm [WHEEL_COUNT];
      longint unsigned mag [WHEEL_COUNT];
      longint unsigned peak, m;
      logic signed [COEF_W-1:0] c [AXIS_COUNT];
      peak = 0;
      for (int w = 0; w < WHEEL_COUNT; w++) begin
         for (int j = 0; j < AXIS_COUNT; j++) c[j] = coeff_q[w][16*j +: 16];
         acc = longint'(c[0]) * v.x + longint'(c[1]) * v.y + longint'(c[2]) * v.t;
         rpm[w] = acc * longint'({1'b0, scale_q});
         mag[w] = rpm[w] < 0 ? -rpm[w] : rpm[w];
         if (mag[w] > peak) peak = mag[w];
      end
      r.clip = peak > (longint'(limit_q) << FRAC);
      for (int w = 0; w < WHEEL_COUNT; w++) begin
         m = r.clip ? (mag[w] * limit_q) / peak : mag[w] >> FRAC;
         if (rpm[w] < 0) r.rpm[w] = (m > 32768) ? 16'sh8000 : SPEED_WIDTH'(-m);
         else r.rpm[w] = (m > 32767) ? 16'sh7fff : SPEED_WIDTH'(m);
      end
      return r;
   endfunction

   // driver
   int gap;
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (gap > 0) begin
         gap <= gap - 1;
         start <= 1'b0;
      end else if (pending_q.size() > 0 && !(start && busy)) begin
         vel_cmd_t v;
         if (!quiet && $urandom_range(0, 5) == 0) begin
            gap <= $urandom_range(0, 3);
            start <= 1'b0;
         end else begin
            v = pending_q.pop_front();
            req_lin_x <= v.x;
            req_lin_y <= v.y;
            req_turn_rate <= v.t;
            start <= 1'b1;
         end
      end else if (!(start && busy)) begin
         start <= 1'b0;
      end
   end

   // request acceptance and response checking
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         vel_cmd_t v;
         v.x = req_lin_x;
         v.y = req_lin_y;
         v.t = req_turn_rate;
         wheel_expect_q.push_back(wheel_speeds(v));
         sent++;
      end
      if (!reset && rsp_valid) begin
         wheel_cmd_t e;
         logic signed [SPEED_WIDTH-1:0] got [WHEEL_COUNT];
         got = '{rsp_rpm_front_left, rsp_rpm_front_right, rsp_rpm_rear_left,
                 rsp_rpm_rear_right};
         if (wheel_expect_q.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            e = wheel_expect_q.pop_front();
            for (int w = 0; w < WHEEL_COUNT; w++)
               if (got[w] !== e.rpm[w]) begin
                  $error("%s: expected %0d, got %0d", wheel_names[w], e.rpm[w], got[w]);
                  errors++;
               end
            if (rsp_clipped !== e.clip) begin
               $error("clipped: expected %0d, got %0d", e.clip, rsp_clipped);
               errors++;
            end
         end
      end
   end

   task automatic wait_drain();
      while (pending_q.size() > 0 || start || wheel_expect_q.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_COEFF_FL, REG_COEFF_FR, REG_COEFF_RL, REG_COEFF_RR: coeff_q[idx[1:0]] = d;
         REG_RPM_SCALE: scale_q = d[SCALE_W-1:0];
         REG_RPM_LIMIT: limit_q = d[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 4096) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_vel();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 6000) - 3000);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_vel(logic [15:0] x, logic [15:0] y, logic [15:0] t);
      vel_cmd_t v;
      v.x = x;
      v.y = y;
      v.t = t;
      pending_q.push_back(v);
   endtask

   initial begin
      coeff_q = '{default: '0};
      scale_q = SCALE_RESET;
      limit_q = LIMIT_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // reset defaults: zero matrix
      push_vel(16'h7fff, 16'h8000, 16'h1234);
      wait_drain();
      // typical omni matrix
      csr_write(REG_COEFF_FL, {16'h0333, 16'hf000, 16'h1000});
      csr_write(REG_COEFF_FR, {16'h0333, 16'h1000, 16'h1000});
      csr_write(REG_COEFF_RL, {16'h0333, 16'hf000, 16'hf000});
      csr_write(REG_COEFF_RR, {16'h0333, 16'h1000, 16'hf000});
      csr_write(REG_SPARE_6, 48'hffff_ffff_ffff);
      csr_write(REG_SPARE_7, 48'h1234_5678_9abc);
      push_vel(16'd0, 16'd0, 16'd0);
      push_vel(16'h7fff, 16'h7fff, 16'h7fff);
      push_vel(16'h8000, 16'h8000, 16'h8000);
      push_vel(16'h8000, 16'd0, 16'd0);
      push_vel(16'd0, 16'h7fff, 16'd0);
      push_vel(16'd0, 16'd0, 16'h8000);
      push_vel(16'd100, 16'(-50), 16'd30);
      push_vel(16'hffff, 16'd1, 16'hffff);
      wait_drain();
      // limit exactly at max: unit coefficient, half scale, 2000 mm/s gives 1000 RPM
      csr_write(REG_COEFF_FL, {16'h0000, 16'h0000, 16'h1000});
      csr_write(REG_RPM_SCALE, 48'h8000);
      csr_write(REG_RPM_LIMIT, 48'd1000);
      push_vel(16'd2000, 16'd0, 16'd0);
      push_vel(16'd2001, 16'd0, 16'd0);
      push_vel(16'(-2001), 16'd0, 16'd0);
      wait_drain();
      csr_write(REG_RPM_SCALE, 48'hffff);
      push_vel(16'd1000, 16'd0, 16'd0);
      push_vel(16'd1001, 16'd0, 16'd0);
      push_vel(16'(-1001), 16'd0, 16'd0);
      push_vel(16'h7fff, 16'h8000, 16'h7fff);
      wait_drain();
      csr_write(REG_RPM_LIMIT, 48'd0);
      push_vel(16'd1, 16'd0, 16'd0);
      push_vel(16'd0, 16'd0, 16'd0);
      push_vel(16'h8000, 16'h7fff, 16'h8000);
      wait_drain();
      csr_write(REG_RPM_LIMIT, 48'h7fff);
      csr_write(REG_RPM_SCALE, 48'h0000);
      push_vel(16'h7fff, 16'h7fff, 16'h7fff);
      wait_drain();
      // random phases with varied settings
      for (int p = 0; p < 11; p++) begin
         for (int w = 0; w < WHEEL_COUNT; w++)
            csr_write(CSR_IDX_W'(w), {rand_coef(), rand_coef(), rand_coef()});
         csr_write(REG_RPM_SCALE, p == 0 ? 48'hffff : p == 1 ? 48'h0001 :
                                  CSR_DATA_W'($urandom_range(0, 65535)));
         csr_write(REG_RPM_LIMIT, p == 2 ? 48'h7fff : p == 3 ? 48'd0 :
                                  p == 4 ? 48'd1 : CSR_DATA_W'($urandom_range(0, 32767)));
         if (p == 10) quiet = 1'b1;
         for (int i = 0; i < 150; i++) push_vel(rand_vel(), rand_vel(), rand_vel());
         wait_drain();
      end
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> filelist.f
sv/ocws_pkg.sv
sv/ocws_front.sv
sv/ocws_div.sv
sv/omni_chassis_wheel_speeds.sv
dv/tb_omni_chassis_wheel_speeds.sv
